[src/ibfd_pkg.sv]
// Shared types and constants of the input box frame decoder.
`default_nettype none
package ibfd_pkg;

    localparam logic [7:0] CHAR_OFFSET = 8'h21;
    localparam logic [7:0] START_CHAR  = 8'h42;
    localparam logic [7:0] END_CHAR    = 8'h0a;
    localparam logic [7:0] AMASK_RST   = 8'd31;
    localparam logic [2:0] DMASK_RST   = 3'd3;
    localparam logic [15:0] ERR_MAX    = 16'hffff;

    typedef enum logic [0:0] {
        CFG_AMASK = 1'b0,
        CFG_DMASK = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_STAGE_DIG = 2'd0,
        OP_STAGE_ANA = 2'd1,
        OP_COMMIT    = 2'd2,
        OP_ERROR     = 2'd3
    } t_op;

    // One command from the parser to the executing side.
    typedef struct packed {
        t_op         op;
        logic [2:0]  idx;
        logic [11:0] data;
        logic [7:0]  amask;
        logic [2:0]  dmask;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

[src/ibfd_rx_if.sv]
// Channel that carries received serial characters.
`default_nettype none
interface ibfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

[src/ibfd_res_if.sv]
// Channel that carries decoded frame results.
`default_nettype none
interface ibfd_res_if;
    logic        valid;
    logic        ready;
    logic        frame_ok;
    logic [15:0] error_count;
    logic [23:0] digital_bits;
    logic [11:0] analog_ch0;
    logic [11:0] analog_ch1;
    logic [11:0] analog_ch2;
    logic [11:0] analog_ch3;
    logic [11:0] analog_ch4;
    logic [11:0] analog_ch5;
    logic [11:0] analog_ch6;
    logic [11:0] analog_ch7;

    modport source (
        output valid, output frame_ok, output error_count, output digital_bits,
        output analog_ch0, output analog_ch1, output analog_ch2, output analog_ch3,
        output analog_ch4, output analog_ch5, output analog_ch6, output analog_ch7,
        input ready
    );
    modport sink (
        input valid, input frame_ok, input error_count, input digital_bits,
        input analog_ch0, input analog_ch1, input analog_ch2, input analog_ch3,
        input analog_ch4, input analog_ch5, input analog_ch6, input analog_ch7,
        output ready
    );
endinterface
`default_nettype wire

[src/ibfd_front.sv]
// Frame parser: tracks the position in the frame and turns the characters into commands.
`default_nettype none
module ibfd_front #(
    parameter int ANALOG_CHANNELS = 8,
    parameter int DIGITAL_GROUPS  = 3
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [0:0]    i_cfg_idx,
    input  wire logic [7:0]    i_cfg_wdata,
    ibfd_rx_if.sink            i_rx,
    input  wire logic          i_q_full,
    output logic               o_push,
    output ibfd_pkg::t_cmd     o_cmd
);
    import ibfd_pkg::*;

    localparam logic [7:0] AMASK_LIM = 8'((1 << ANALOG_CHANNELS) - 1);
    localparam logic [2:0] DMASK_LIM = 3'((1 << DIGITAL_GROUPS) - 1);

    function automatic logic [3:0] popcnt8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) n = n + 4'(v[i]);
        return n;
    endfunction

    // Position of the idx-th set bit, counted from the top of a 3-bit mask.
    function automatic logic [1:0] nth_top3(input logic [2:0] m, input logic [3:0] idx);
        logic [1:0] r;
        logic [3:0] cnt;
        logic       hit;
        r   = '0;
        cnt = idx;
        hit = 1'b0;
        for (int j = 2; j >= 0; j--) begin
            if (m[j] && !hit) begin
                if (cnt == 4'd0) begin
                    r   = 2'(j);
                    hit = 1'b1;
                end else begin
                    cnt = cnt - 4'd1;
                end
            end
        end
        return r;
    endfunction

    // Position of the idx-th set bit, counted from the bottom of an 8-bit mask.
    function automatic logic [2:0] nth_bot8(input logic [7:0] m, input logic [3:0] idx);
        logic [2:0] r;
        logic [3:0] cnt;
        logic       hit;
        r   = '0;
        cnt = idx;
        hit = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (m[k] && !hit) begin
                if (cnt == 4'd0) begin
                    r   = 3'(k);
                    hit = 1'b1;
                end else begin
                    cnt = cnt - 4'd1;
                end
            end
        end
        return r;
    endfunction

    logic [7:0] r_amask;
    logic [2:0] r_dmask;
    logic [4:0] r_pos,  n_pos;
    logic [5:0] r_high, n_high;

    logic [7:0] am, ch_c;
    logic [2:0] dm;
    logic [3:0] na;
    logic [1:0] nd;
    logic [4:0] last, k, k2, two_nd;
    logic       cmd_vld;
    t_cmd       cmd;
    logic       acc;

    assign am     = r_amask & AMASK_LIM;
    assign dm     = r_dmask & DMASK_LIM;
    assign na     = popcnt8(am);
    assign nd     = 2'(popcnt8({5'd0, dm}));
    assign last   = 5'd1 + {na, 1'b0} + {2'd0, nd, 1'b0};
    assign two_nd = {2'd0, nd, 1'b0};
    assign k      = r_pos - 5'd1;
    assign k2     = k - two_nd;
    assign ch_c   = i_rx.rx_byte - CHAR_OFFSET;

    assign i_rx.ready = !i_q_full;
    assign acc        = i_rx.valid && i_rx.ready;

    always_comb begin
        n_pos     = r_pos;
        n_high    = r_high;
        cmd_vld   = 1'b0;
        cmd.op    = OP_ERROR;
        cmd.idx   = '0;
        cmd.data  = '0;
        cmd.amask = am;
        cmd.dmask = dm;
        if (r_pos == 5'd0) begin
            if (i_rx.rx_byte != START_CHAR) begin
                cmd_vld = 1'b1;
                cmd.op  = OP_ERROR;
            end else begin
                n_pos = 5'd1;
            end
        end else if (r_pos >= last) begin
            // end of frame: commit on newline, error otherwise
            cmd_vld = 1'b1;
            cmd.op  = (i_rx.rx_byte == END_CHAR) ? OP_COMMIT : OP_ERROR;
            n_pos   = 5'd0;
        end else begin
            n_pos = r_pos + 5'd1;
            if (k < two_nd) begin
                if (!k[0]) begin
                    n_high = {2'd0, ch_c[3:0]};
                end else begin
                    cmd_vld  = 1'b1;
                    cmd.op   = OP_STAGE_DIG;
                    cmd.idx  = {1'b0, nth_top3(dm, k[4:1])};
                    cmd.data = {4'd0, r_high[3:0], ch_c[3:0]};
                end
            end else begin
                if (!k2[0]) begin
                    n_high = ch_c[5:0];
                end else begin
                    cmd_vld  = 1'b1;
                    cmd.op   = OP_STAGE_ANA;
                    cmd.idx  = nth_bot8(am, k2[4:1]);
                    cmd.data = {r_high, ch_c[5:0]};
                end
            end
        end
    end

    assign o_push = acc && cmd_vld;
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amask <= AMASK_RST;
            r_dmask <= DMASK_RST;
            r_pos   <= '0;
            r_high  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_AMASK: r_amask <= i_cfg_wdata;
                    CFG_DMASK: r_dmask <= i_cfg_wdata[2:0];
                    default:   r_amask <= r_amask;
                endcase
            end
            if (acc) begin
                r_pos  <= n_pos;
                r_high <= n_high;
            end
        end
    end
endmodule
`default_nettype wire

[src/ibfd_cmd_fifo.sv]
// Two-entry command queue between the parser and the executing side.
`default_nettype none
module ibfd_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ibfd_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output ibfd_pkg::t_cmd     o_head,
    output ibfd_pkg::t_q_stat  o_stat
);
    import ibfd_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign do_push      = i_push && (r_cnt != 2'd2);
    assign do_pop       = i_pop && (r_cnt != 2'd0);
    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule
`default_nettype wire

[src/ibfd_back.sv]
// Executing side: staged values, shadows, error counter and the result register.
`default_nettype none
module ibfd_back #(
    parameter int ANALOG_CHANNELS = 8,
    parameter int DIGITAL_GROUPS  = 3
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ibfd_pkg::t_cmd i_head,
    input  wire logic           i_empty,
    output logic                o_pop,
    ibfd_res_if.source          o_res
);
    import ibfd_pkg::*;

    logic [11:0]                 r_stg_ana [ANALOG_CHANNELS];
    logic [11:0]                 r_ana_sh  [ANALOG_CHANNELS];
    logic [8*DIGITAL_GROUPS-1:0] r_stg_dig;
    logic [8*DIGITAL_GROUPS-1:0] r_dig_sh;
    logic [15:0]                 r_errors;
    logic                        r_ok;
    logic                        r_out_vld;
    logic [11:0]                 ana_out [8];
    logic                        is_stage, out_free;

    assign is_stage = (i_head.op == OP_STAGE_DIG) || (i_head.op == OP_STAGE_ANA);
    assign out_free = !r_out_vld || o_res.ready;
    // staging commands never wait on the receiver
    assign o_pop    = !i_empty && (is_stage || out_free);

    // staged stores: undefined until written, no reset
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            case (i_head.op)
                OP_STAGE_DIG: begin
                    for (int j = 0; j < DIGITAL_GROUPS; j++) begin
                        if (i_head.idx == 3'(j)) r_stg_dig[8*j +: 8] <= i_head.data[7:0];
                    end
                end
                OP_STAGE_ANA: begin
                    for (int c = 0; c < ANALOG_CHANNELS; c++) begin
                        if (i_head.idx == 3'(c)) r_stg_ana[c] <= i_head.data;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < ANALOG_CHANNELS; c++) r_ana_sh[c] <= '0;
            r_dig_sh  <= '0;
            r_errors  <= '0;
            r_ok      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_res.ready) r_out_vld <= 1'b0;
            if (o_pop) begin
                case (i_head.op)
                    OP_COMMIT: begin
                        for (int j = 0; j < DIGITAL_GROUPS; j++) begin
                            if (i_head.dmask[j]) r_dig_sh[8*j +: 8] <= r_stg_dig[8*j +: 8];
                        end
                        for (int c = 0; c < ANALOG_CHANNELS; c++) begin
                            if (i_head.amask[c]) r_ana_sh[c] <= r_stg_ana[c];
                        end
                        r_ok      <= 1'b1;
                        r_out_vld <= 1'b1;
                    end
                    OP_ERROR: begin
                        if (r_errors != ERR_MAX) r_errors <= r_errors + 16'd1;
                        r_ok      <= 1'b0;
                        r_out_vld <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Shadows never change under a waiting result, so they feed the result directly.
    for (genvar g = 0; g < 8; g++) begin : g_ana
        if (g < ANALOG_CHANNELS) begin : g_on
            assign ana_out[g] = r_ana_sh[g];
        end else begin : g_off
            assign ana_out[g] = '0;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.frame_ok     = r_ok;
    assign o_res.error_count  = r_errors;
    assign o_res.digital_bits = 24'(r_dig_sh);
    assign o_res.analog_ch0   = ana_out[0];
    assign o_res.analog_ch1   = ana_out[1];
    assign o_res.analog_ch2   = ana_out[2];
    assign o_res.analog_ch3   = ana_out[3];
    assign o_res.analog_ch4   = ana_out[4];
    assign o_res.analog_ch5   = ana_out[5];
    assign o_res.analog_ch6   = ana_out[6];
    assign o_res.analog_ch7   = ana_out[7];
endmodule
`default_nettype wire

[src/input_box_frame_decoder.sv]
// Top level of the input box frame decoder.
//
// i_rx carries one received serial character per item (valid/ready).
// o_res carries one result per frame end: frame_ok=1 after a good frame
// (shadows committed) or frame_ok=0 after a bad start or end character,
// with the saturating error count, digital shadow and analog raw codes.
// i_cfg_we/i_cfg_idx/i_cfg_wdata write analog_mask (index 0) and
// digital_group_mask (index 1); write them only while the block is idle.
// Throughput: one character per cycle unless the queue is full. The
// parser classifies a character in the cycle it is accepted; the command
// is written into a two-entry queue, and the executing side registers the
// result when it pops the command for the frame's last character.
// When the receiver stalls, the result holds; staging commands keep
// draining, and the input is held off only once the queue is full.
// Synchronous active-low reset clears the frame position, masks (to 31
// and 3), shadows, error count and the result register.
`default_nettype none
module input_box_frame_decoder #(
    parameter int ANALOG_CHANNELS = 8,
    parameter int DIGITAL_GROUPS  = 3
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [0:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_wdata,
    ibfd_rx_if.sink         i_rx,
    ibfd_res_if.source      o_res
);
    import ibfd_pkg::*;

    logic    push, pop;
    t_cmd    cmd, head;
    t_q_stat q_stat;

    ibfd_front #(
        .ANALOG_CHANNELS(ANALOG_CHANNELS),
        .DIGITAL_GROUPS (DIGITAL_GROUPS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_rx       (i_rx),
        .i_q_full   (q_stat.full),
        .o_push     (push),
        .o_cmd      (cmd)
    );

    ibfd_cmd_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (cmd),
        .i_pop  (pop),
        .o_head (head),
        .o_stat (q_stat)
    );

    ibfd_back #(
        .ANALOG_CHANNELS(ANALOG_CHANNELS),
        .DIGITAL_GROUPS (DIGITAL_GROUPS)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_head (head),
        .i_empty(q_stat.empty),
        .o_pop  (pop),
        .o_res  (o_res)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("command popped from an empty queue");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid right after reset");

    a_err_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && head.op == OP_ERROR && o_res.error_count != ERR_MAX)
            |=> o_res.error_count == $past(o_res.error_count) + 16'd1)
        else $error("error counter did not advance on a framing error");
endmodule
`default_nettype wire

[dv/input_box_frame_decoder_tb.sv]
// Self-checking testbench of the input box frame decoder: directed frames, then random traffic.
`timescale 1ns / 1ps
module input_box_frame_decoder_tb;
    import ibfd_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int DIR_ROWS      = 28;
    localparam int PHASES        = 8;
    localparam int PHASE_CHARS   = 250;

    typedef struct packed {
        logic             ok;
        logic [15:0]      errs;
        logic [23:0]      dig;
        logic [7:0][11:0] ana;
    } t_frame_report;

    typedef enum logic {ROW_CHAR, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind     kind;
        t_cfg_idx      reg_idx;
        logic [7:0]    val;
        bit            pinned;
        t_frame_report want;
    } t_stim_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [0:0] i_cfg_idx;
    logic [7:0] i_cfg_wdata;

    ibfd_rx_if  rx_ch ();
    ibfd_res_if res_ch ();

    input_box_frame_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (rx_ch),
        .o_res       (res_ch)
    );

    // Decoder state as the testbench expects it
    logic [7:0]  am_reg;
    logic [2:0]  dm_reg;
    logic [4:0]  pos;
    logic [5:0]  high_bits;
    logic [11:0] stg_ana [8];
    logic [23:0] stg_dig;
    logic [11:0] shd_ana [8];
    logic [23:0] shd_dig;
    logic [15:0] err_cnt;

    t_frame_report reports_due [$];
    int            mismatches  = 0;
    int            cycle_count = 0;
    int            chars_sent  = 0;
    bit            no_gaps     = 1'b0;

    always #5 i_clk = ~i_clk;

    function automatic int frame_last();
        return 1 + 2 * ($countones(am_reg) + $countones(dm_reg));
    endfunction

    function automatic t_frame_report shadow_report(input logic ok);
        t_frame_report rpt;
        int            i;
        rpt.ok   = ok;
        rpt.errs = err_cnt;
        rpt.dig  = shd_dig;
        for (i = 0; i < 8; i++) rpt.ana[i] = shd_ana[i];
        return rpt;
    endfunction

    // Advance the decoder by one character; return 1 when the character yields a frame result.
    function automatic bit decode_char(input logic [7:0] ch, output t_frame_report rpt);
        logic [7:0] pay;
        int         nd;
        int         k;
        int         seen;
        int         sel;
        int         j;
        pay  = ch - CHAR_OFFSET;
        nd   = $countones(dm_reg);
        rpt  = '0;
        seen = 0;
        sel  = 0;
        if (pos == 0) begin
            if (ch == START_CHAR) begin
                pos = 5'd1;
                return 1'b0;
            end
        end else if (pos < frame_last()) begin
            k = pos - 1;
            if (k < 2 * nd) begin
                // digital groups run from the highest enabled one down
                for (j = 2; j >= 0; j--) begin
                    if (dm_reg[j]) begin
                        if (seen == k / 2) sel = j;
                        seen++;
                    end
                end
                if (k % 2 == 0) high_bits = {2'b00, pay[3:0]};
                else stg_dig[8 * sel +: 8] = {high_bits[3:0], pay[3:0]};
            end else begin
                k = k - 2 * nd;
                for (j = 0; j < 8; j++) begin
                    if (am_reg[j]) begin
                        if (seen == k / 2) sel = j;
                        seen++;
                    end
                end
                if (k % 2 == 0) high_bits = pay[5:0];
                else stg_ana[sel] = {high_bits, pay[5:0]};
            end
            pos++;
            return 1'b0;
        end else if (ch == END_CHAR) begin
            for (j = 0; j < 3; j++) begin
                if (dm_reg[j]) shd_dig[8 * j +: 8] = stg_dig[8 * j +: 8];
            end
            for (j = 0; j < 8; j++) begin
                if (am_reg[j]) shd_ana[j] = stg_ana[j];
            end
            pos = '0;
            rpt = shadow_report(1'b1);
            return 1'b1;
        end
        if (err_cnt != ERR_MAX) err_cnt++;
        pos = '0;
        rpt = shadow_report(1'b0);
        return 1'b1;
    endfunction

    task automatic send_char(input logic [7:0] ch, input bit pinned = 1'b0,
                             input t_frame_report pinned_rpt = '0);
        t_frame_report rpt;
        bit            has_rpt;
        if (!no_gaps) begin
            while ($urandom_range(99) < 15) begin
                rx_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= ch;
        do begin
            @(posedge i_clk);
        end while (!(rx_ch.valid && rx_ch.ready));
        has_rpt = decode_char(ch, rpt);
        if (has_rpt || pinned) reports_due.push_back(pinned ? pinned_rpt : rpt);
        chars_sent++;
    endtask

    // Write one mask once the decoder has delivered everything and gone quiet.
    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] val);
        rx_ch.valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_AMASK) am_reg = val;
        else dm_reg = val[2:0];
    endtask

    // Complete the frame in progress so that a mask change never commits stale staging.
    task automatic finish_frame();
        while (pos != 0)
            send_char(pos >= frame_last() ? END_CHAR : 8'(CHAR_OFFSET + $urandom_range(63)));
    endtask

    task automatic send_random_frame();
        int         pick;
        int         nbytes;
        logic [7:0] ch;
        pick   = $urandom_range(99);
        nbytes = frame_last() - 1;
        if (pick >= 93) begin
            repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(255)));
            return;
        end
        // truncated frame: the newline lands on a data position
        if (pick >= 85) nbytes = $urandom_range(0, nbytes);
        send_char(START_CHAR);
        repeat (nbytes) begin
            if ($urandom_range(9) == 0) ch = 8'($urandom_range(255));
            else ch = 8'(CHAR_OFFSET + $urandom_range(63));
            send_char(ch);
        end
        ch = END_CHAR;
        if (pick >= 75 && pick < 85) begin
            ch = 8'($urandom_range(255));
            if (ch == END_CHAR) ch = ~END_CHAR;
        end
        send_char(ch);
    endtask

    initial begin
        t_stim_row  script [DIR_ROWS];
        int         i;
        int         ph;
        int         phase_end;
        logic [7:0] amask_pick;
        logic [2:0] dmask_pick;

        script = '{
            // bad start characters at both ends of the byte range
            '{ROW_CHAR, CFG_AMASK, 8'h00, 1'b1,
              '{ok: 1'b0, errs: 16'd1, dig: 24'd0, ana: '0}},
            '{ROW_CHAR, CFG_AMASK, 8'hff, 1'b1,
              '{ok: 1'b0, errs: 16'd2, dig: 24'd0, ana: '0}},
            '{ROW_REG, CFG_AMASK, 8'h81, 1'b0, '0},
            '{ROW_REG, CFG_DMASK, 8'h04, 1'b0, '0},
            // group 2 all ones, channel 0 full scale, channel 7 zero
            '{ROW_CHAR, CFG_AMASK, START_CHAR, 1'b0, '0},
            '{ROW_CHAR, CFG_AMASK, 8'h30, 1'b0, '0},
            '{ROW_CHAR, CFG_AMASK, 8'h30, 1'b0, '0},
            '{ROW_CHAR, CFG_AMASK, 8'h60, 1'b0, '0},
            '{ROW_CHAR, CFG_AMASK, 8'h60, 1'b0, '0},
            '{ROW_CHAR, CFG_AMASK, 8'h21, 1'b0, '0},
            '{ROW_CHAR, CFG_AMASK, 8'h21, 1'b0, '0},
            '{ROW_CHAR, CFG_AMASK, END_CHAR, 1'b1,
              '{ok: 1'b1, errs: 16'd2, dig: 24'hff0000, ana: 96'hfff}},
            // characters below the offset wrap before masking
            '{ROW_CHAR, CFG_AMASK, START_CHAR, 1'b0, '0},
            '{ROW_CHAR, CFG_AMASK, 8'h00, 1'b0, '0},
            '{ROW_CHAR, CFG_AMASK, 8'h20, 1'b0, '0},
            '{ROW_CHAR, CFG_AMASK, 8'h00, 1'b0, '0},
            '{ROW_CHAR, CFG_AMASK, 8'h20, 1'b0, '0},
            '{ROW_CHAR, CFG_AMASK, 8'hff, 1'b0, '0},
            '{ROW_CHAR, CFG_AMASK, 8'h7f, 1'b0, '0},
            '{ROW_CHAR, CFG_AMASK, END_CHAR, 1'b0, '0},
            // shrink the frame mid-way, then a bad end character
            '{ROW_CHAR, CFG_AMASK, START_CHAR, 1'b0, '0},
            '{ROW_CHAR, CFG_AMASK, 8'h26, 1'b0, '0},
            '{ROW_CHAR, CFG_AMASK, 8'h2b, 1'b0, '0},
            '{ROW_REG, CFG_AMASK, 8'h00, 1'b0, '0},
            '{ROW_CHAR, CFG_AMASK, 8'h58, 1'b0, '0},
            // empty frame with both masks cleared
            '{ROW_REG, CFG_DMASK, 8'h00, 1'b0, '0},
            '{ROW_CHAR, CFG_AMASK, START_CHAR, 1'b0, '0},
            '{ROW_CHAR, CFG_AMASK, END_CHAR, 1'b0, '0}
        };

        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_AMASK;
        i_cfg_wdata   <= 8'h00;
        i_rst_n       <= 1'b0;
        am_reg    = AMASK_RST;
        dm_reg    = DMASK_RST;
        pos       = '0;
        high_bits = '0;
        stg_dig   = '0;
        shd_dig   = '0;
        err_cnt   = '0;
        for (i = 0; i < 8; i++) begin
            stg_ana[i] = '0;
            shd_ana[i] = '0;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[r]) begin
            if (script[r].kind == ROW_REG) write_reg(script[r].reg_idx, script[r].val);
            else send_char(script[r].val, script[r].pinned, script[r].want);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    amask_pick = 8'hff;
                    dmask_pick = 3'h7;
                end
                1: begin
                    amask_pick = 8'h00;
                    dmask_pick = 3'h0;
                end
                2: begin
                    amask_pick = 8'h01;
                    dmask_pick = 3'h1;
                end
                3: begin
                    amask_pick = 8'h80;
                    dmask_pick = 3'h4;
                end
                default: begin
                    amask_pick = 8'($urandom_range(255));
                    dmask_pick = 3'($urandom_range(7));
                end
            endcase
            finish_frame();
            write_reg(CFG_AMASK, amask_pick);
            // upper data bits of the group mask write are don't-care
            write_reg(CFG_DMASK, {5'($urandom_range(31)), dmask_pick});
            no_gaps   = (ph == 4);
            phase_end = chars_sent + PHASE_CHARS;
            while (chars_sent < phase_end) send_random_frame();
        end
        no_gaps = 1'b0;

        rx_ch.valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && reports_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Result side: random back-pressure and comparison against the oldest expectation
    initial begin
        t_frame_report got;
        t_frame_report want;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= no_gaps || ($urandom_range(99) >= 15);
                if (res_ch.valid && res_ch.ready) begin
                    got = {res_ch.frame_ok, res_ch.error_count, res_ch.digital_bits,
                           res_ch.analog_ch7, res_ch.analog_ch6, res_ch.analog_ch5,
                           res_ch.analog_ch4, res_ch.analog_ch3, res_ch.analog_ch2,
                           res_ch.analog_ch1, res_ch.analog_ch0};
                    if (reports_due.size() == 0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("unexpected frame result: ok=%0d err=%0d dig=%h ana=%h",
                                     got.ok, got.errs, got.dig, got.ana);
                    end else begin
                        want = reports_due.pop_front();
                        if (got.ok !== want.ok || got.errs !== want.errs ||
                            got.dig !== want.dig || got.ana !== want.ana) begin
                            mismatches++;
                            if (mismatches <= 10) begin
                                $display("frame result mismatch at %0t", $realtime);
                                $display("  expected ok=%0d err=%0d dig=%h ana=%h",
                                         want.ok, want.errs, want.dig, want.ana);
                                $display("  actual   ok=%0d err=%0d dig=%h ana=%h",
                                         got.ok, got.errs, got.dig, got.ana);
                            end
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
